### rtl/gprgb_pkg.sv
// ---------------------------------------------------------------------------
// gprgb_pkg: shared constants and types
// Fixed-point widths, register indexes and pipeline tag for the gradient
// point to RGB converter.
// ---------------------------------------------------------------------------
package gprgb_pkg;

   localparam int FRAC_BITS = 16;                 // fraction bits of every fixed-point value
   localparam int COORD_W   = 16;                 // point coordinate width
   localparam int SIZE_W    = 12;                 // area width / height
   localparam int NUM_W     = SIZE_W + 3;         // 6*x fits below 8*4096
   localparam int QUO_W     = FRAC_BITS + 3;      // quotients stay below 6.0
   localparam int FX_W      = FRAC_BITS + 1;      // fraction that may equal one
   localparam int BYTE_W    = 8;

   localparam logic [FX_W-1:0] FX_ONE = FX_W'(1) << FRAC_BITS;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_AREA_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_AREA_HEIGHT = 1'b1;

   localparam logic [2:0] SECTOR_0 = 3'd0;
   localparam logic [2:0] SECTOR_1 = 3'd1;
   localparam logic [2:0] SECTOR_2 = 3'd2;
   localparam logic [2:0] SECTOR_3 = 3'd3;
   localparam logic [2:0] SECTOR_4 = 3'd4;
   localparam logic [2:0] SECTOR_5 = 3'd5;

   // side info that rides along with the dividers
   typedef struct packed {
      logic valid;
      logic upper;    // point in upper half: v is one
      logic s_zero;   // half is zero: saturation forced to zero
      logic w_zero;   // width is zero: hue forced to zero
   } tag_type;

endpackage

### rtl/gradient_point_to_rgb.sv
// ---------------------------------------------------------------------------
// gradient_point_to_rgb: color-picker gradient sample
// Maps a point of a width x height gradient to an RGB color through a
// fixed-point HSV to RGB conversion.
// ---------------------------------------------------------------------------
// A point is taken at every clock edge with start high; busy is always low.
// Each point yields one color, shown for one cycle with rsp_valid high; the
// receiver cannot stall, so it must take every transfer. Throughput is one
// point per clock. The three pipelined dividers (hue, saturation,
// brightness) each retire one quotient bit per stage. Write area_width
// and area_height only while no point is in flight.
module gradient_point_to_rgb (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_wr_en,
   input  logic [gprgb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gprgb_pkg::SIZE_W-1:0]        csr_wr_data,
   // point in
   input  logic                                start,
   output logic                                busy,
   input  logic signed [gprgb_pkg::COORD_W-1:0] req_point_x,
   input  logic signed [gprgb_pkg::COORD_W-1:0] req_point_y,
   // color out
   output logic                                rsp_valid,
   output logic [gprgb_pkg::BYTE_W-1:0]        rsp_red,
   output logic [gprgb_pkg::BYTE_W-1:0]        rsp_green,
   output logic [gprgb_pkg::BYTE_W-1:0]        rsp_blue
);

   localparam int FB  = gprgb_pkg::FRAC_BITS;
   localparam int QW  = gprgb_pkg::QUO_W;
   localparam int SW  = gprgb_pkg::SIZE_W;
   localparam int CW  = gprgb_pkg::COORD_W;
   localparam int NW  = gprgb_pkg::NUM_W;
   localparam int XW  = gprgb_pkg::FX_W;
   localparam int BW  = gprgb_pkg::BYTE_W;
   localparam int LAT = QW + 6;

   // ---------------- configuration registers ----------------
   logic [SW-1:0] width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SW'(100);
         height_ff <= SW'(150);
      end else if (csr_wr_en) begin
         case (csr_index)
            gprgb_pkg::CSR_AREA_WIDTH:  width_ff  <= csr_wr_data;
            gprgb_pkg::CSR_AREA_HEIGHT: height_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // every cycle is open for a new point
   assign busy = 1'b0;

   logic accept;
   assign accept = start & ~busy;

   // ---------------- stage 1: clamp into the area ----------------
   logic          s1_valid_ff;
   logic [SW-1:0] x_c_ff, y_c_ff;
   logic [SW-1:0] x_c_in, y_c_in;

   always_comb begin
      // negative -> 0, at or past the edge -> size-1 (0 for zero size)
      if (req_point_x[CW-1])
         x_c_in = '0;
      else if (req_point_x >= $signed({{(CW-SW){1'b0}}, width_ff}))
         x_c_in = (width_ff == '0) ? '0 : width_ff - SW'(1);
      else
         x_c_in = req_point_x[SW-1:0];

      if (req_point_y[CW-1])
         y_c_in = '0;
      else if (req_point_y >= $signed({{(CW-SW){1'b0}}, height_ff}))
         y_c_in = (height_ff == '0) ? '0 : height_ff - SW'(1);
      else
         y_c_in = req_point_y[SW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= accept;
      x_c_ff <= x_c_in;
      y_c_ff <= y_c_in;
   end

   // ---------------- stage 2: divider operands ----------------
   gprgb_pkg::tag_type tag2_ff, tag2_in;
   logic [NW-1:0] h_num_ff, s_num_ff, v_num_ff;
   logic [SW-1:0] h_den_ff, s_den_ff, v_den_ff;
   logic [NW-1:0] h_num_in, s_num_in, v_num_in;
   logic [SW-1:0] s_den_in;
   logic [SW-1:0] half;
   logic [SW-1:0] twice_half;

   always_comb begin
      half       = height_ff >> 1;
      twice_half = {half[SW-2:0], 1'b0};
      tag2_in.valid  = s1_valid_ff;
      tag2_in.upper  = (y_c_ff <= half);
      tag2_in.s_zero = tag2_in.upper & (half == '0);
      tag2_in.w_zero = (width_ff == '0);
      // hue: 6x / width
      h_num_in = NW'(x_c_ff) * NW'(6);
      // saturation: y / half above, half / y below
      s_num_in = tag2_in.upper ? NW'(y_c_ff) : NW'(half);
      s_den_in = tag2_in.upper ? half : y_c_ff;
      // brightness below: (2*half - y) / y; unused above
      v_num_in = tag2_in.upper ? '0 : NW'(twice_half - y_c_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) tag2_ff.valid <= 1'b0;
      else       tag2_ff.valid <= tag2_in.valid;
      tag2_ff.upper  <= tag2_in.upper;
      tag2_ff.s_zero <= tag2_in.s_zero;
      tag2_ff.w_zero <= tag2_in.w_zero;
      h_num_ff <= h_num_in;
      h_den_ff <= width_ff;
      s_num_ff <= s_num_in;
      s_den_ff <= s_den_in;
      v_num_ff <= v_num_in;
      v_den_ff <= y_c_ff;
   end

   // ---------------- dividers, QW stages ----------------
   logic [QW-1:0] h_quo, s_quo, v_quo;

   gprgb_div u_div_hue (.clock(clock), .in_num(h_num_ff), .in_den(h_den_ff), .out_quo(h_quo));
   gprgb_div u_div_sat (.clock(clock), .in_num(s_num_ff), .in_den(s_den_ff), .out_quo(s_quo));
   gprgb_div u_div_val (.clock(clock), .in_num(v_num_ff), .in_den(v_den_ff), .out_quo(v_quo));

   // tag line beside the dividers
   gprgb_pkg::tag_type tag_line_ff [0:QW-1];

   always_ff @(posedge clock) begin
      for (int i = 0; i < QW; i++) begin
         if (reset)       tag_line_ff[i] <= '0;
         else if (i == 0) tag_line_ff[i] <= tag2_ff;
         else             tag_line_ff[i] <= tag_line_ff[i-1];
      end
   end

   gprgb_pkg::tag_type tag_d;
   assign tag_d = tag_line_ff[QW-1];

   // ---------------- stage E: resolve h, s, v ----------------
   logic          e_valid_ff;
   logic [2:0]    sector_e_ff, sector_e_in;
   logic [FB-1:0] f_e_ff, f_e_in;
   logic [XW-1:0] s_e_ff, s_e_in, v_e_ff, v_e_in;
   logic [QW-1:0] h6;

   always_comb begin
      h6          = tag_d.w_zero ? '0 : h_quo;
      sector_e_in = h6[QW-1:FB];
      f_e_in      = h6[FB-1:0];
      if (tag_d.s_zero)
         s_e_in = '0;
      else if (s_quo > QW'(gprgb_pkg::FX_ONE))
         s_e_in = gprgb_pkg::FX_ONE;
      else
         s_e_in = s_quo[XW-1:0];
      v_e_in = tag_d.upper ? gprgb_pkg::FX_ONE : v_quo[XW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) e_valid_ff <= 1'b0;
      else       e_valid_ff <= tag_d.valid;
      sector_e_ff <= sector_e_in;
      f_e_ff      <= f_e_in;
      s_e_ff      <= s_e_in;
      v_e_ff      <= v_e_in;
   end

   // ---------------- stage F: s*f, s*(1-f) ----------------
   logic            f_valid_ff;
   logic [2:0]      sector_f_ff;
   logic [XW-1:0]   v_f_ff;
   logic [XW-1:0]   a_f_ff, b_f_ff, c_f_ff;   // 1-s*f, 1-s*(1-f), 1-s
   logic [2*XW-1:0] sf_prod, sg_prod;
   logic [XW-1:0]   a_f_in, b_f_in, c_f_in;

   always_comb begin
      sf_prod = (2*XW)'(s_e_ff) * (2*XW)'({1'b0, f_e_ff});
      sg_prod = (2*XW)'(s_e_ff) * (2*XW)'(gprgb_pkg::FX_ONE - {1'b0, f_e_ff});
      a_f_in  = gprgb_pkg::FX_ONE - sf_prod[2*FB:FB];
      b_f_in  = gprgb_pkg::FX_ONE - sg_prod[2*FB:FB];
      c_f_in  = gprgb_pkg::FX_ONE - s_e_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) f_valid_ff <= 1'b0;
      else       f_valid_ff <= e_valid_ff;
      sector_f_ff <= sector_e_ff;
      v_f_ff      <= v_e_ff;
      a_f_ff      <= a_f_in;
      b_f_ff      <= b_f_in;
      c_f_ff      <= c_f_in;
   end

   // ---------------- stage G: p, q, t ----------------
   logic            g_valid_ff;
   logic [2:0]      sector_g_ff;
   logic [XW-1:0]   v_g_ff, p_g_ff, q_g_ff, t_g_ff;
   logic [2*XW-1:0] p_prod, q_prod, t_prod;

   always_comb begin
      p_prod = (2*XW)'(v_f_ff) * (2*XW)'(c_f_ff);
      q_prod = (2*XW)'(v_f_ff) * (2*XW)'(a_f_ff);
      t_prod = (2*XW)'(v_f_ff) * (2*XW)'(b_f_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) g_valid_ff <= 1'b0;
      else       g_valid_ff <= f_valid_ff;
      sector_g_ff <= sector_f_ff;
      v_g_ff      <= v_f_ff;
      p_g_ff      <= p_prod[2*FB:FB];
      q_g_ff      <= q_prod[2*FB:FB];
      t_g_ff      <= t_prod[2*FB:FB];
   end

   // ---------------- stage H: sector select, scale to bytes ----------------
   logic          rsp_valid_ff;
   logic [BW-1:0] red_ff, green_ff, blue_ff;
   logic [XW-1:0] r_sel, g_sel, b_sel;
   logic [XW+BW-1:0] r_sc, g_sc, b_sc;

   always_comb begin
      case (sector_g_ff)
         gprgb_pkg::SECTOR_0: begin r_sel = v_g_ff; g_sel = t_g_ff; b_sel = p_g_ff; end
         gprgb_pkg::SECTOR_1: begin r_sel = q_g_ff; g_sel = v_g_ff; b_sel = p_g_ff; end
         gprgb_pkg::SECTOR_2: begin r_sel = p_g_ff; g_sel = v_g_ff; b_sel = t_g_ff; end
         gprgb_pkg::SECTOR_3: begin r_sel = p_g_ff; g_sel = q_g_ff; b_sel = v_g_ff; end
         gprgb_pkg::SECTOR_4: begin r_sel = t_g_ff; g_sel = p_g_ff; b_sel = v_g_ff; end
         default:             begin r_sel = v_g_ff; g_sel = p_g_ff; b_sel = q_g_ff; end
      endcase
      // c*255 as (c << 8) - c
      r_sc = {r_sel, {BW{1'b0}}} - (XW+BW)'(r_sel);
      g_sc = {g_sel, {BW{1'b0}}} - (XW+BW)'(g_sel);
      b_sc = {b_sel, {BW{1'b0}}} - (XW+BW)'(b_sel);
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= g_valid_ff;
      red_ff   <= r_sc[FB+BW-1:FB];
      green_ff <= g_sc[FB+BW-1:FB];
      blue_ff  <= b_sc[FB+BW-1:FB];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

`ifndef SYNTHESIS
   // every accepted point comes out as a color with rsp_valid high
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT rsp_valid)
      else $error("accepted point did not produce a color on time");

   // hue sector never past the sixth
   a_sector: assert property (@(posedge clock) disable iff (reset)
      e_valid_ff |-> (sector_e_ff <= gprgb_pkg::SECTOR_5))
      else $error("hue sector out of range");

   // saturation and brightness never above one
   a_sat_range: assert property (@(posedge clock) disable iff (reset)
      e_valid_ff |-> (s_e_ff <= gprgb_pkg::FX_ONE))
      else $error("saturation above one");

   a_val_range: assert property (@(posedge clock) disable iff (reset)
      e_valid_ff |-> (v_e_ff <= gprgb_pkg::FX_ONE))
      else $error("brightness above one");
`endif

endmodule

### rtl/gprgb_div.sv
// ---------------------------------------------------------------------------
// gprgb_div: pipelined restoring divider
// Computes (num << FRAC_BITS) / den, one quotient bit per register stage.
// The quotient must fit QUO_W bits; otherwise the result is meaningless.
// ---------------------------------------------------------------------------
module gprgb_div (
   input  logic                           clock,
   input  logic [gprgb_pkg::NUM_W-1:0]    in_num,
   input  logic [gprgb_pkg::SIZE_W-1:0]   in_den,
   output logic [gprgb_pkg::QUO_W-1:0]    out_quo
);

   localparam int QW = gprgb_pkg::QUO_W;
   localparam int SW = gprgb_pkg::SIZE_W;

   logic [SW-1:0] rem_ff [0:QW-1];
   logic [QW-1:0] low_ff [0:QW-1];
   logic [QW-1:0] quo_ff [0:QW-1];
   logic [SW-1:0] den_ff [0:QW-1];

   genvar k;
   generate
      for (k = 0; k < QW; k++) begin : g_stage
         logic [SW-1:0] rem_prev;
         logic [QW-1:0] low_prev;
         logic [QW-1:0] quo_prev;
         logic [SW-1:0] den_prev;
         logic [SW:0]   rem_sh;
         logic [SW:0]   rem_sub;
         logic          ge;
         logic [SW-1:0] rem_in;

         if (k == 0) begin : g_first
            // top bits of the dividend are num >> 3, below den by range
            assign rem_prev = in_num[gprgb_pkg::NUM_W-1:3];
            assign low_prev = {in_num[2:0], {gprgb_pkg::FRAC_BITS{1'b0}}};
            assign quo_prev = '0;
            assign den_prev = in_den;
         end else begin : g_next
            assign rem_prev = rem_ff[k-1];
            assign low_prev = low_ff[k-1];
            assign quo_prev = quo_ff[k-1];
            assign den_prev = den_ff[k-1];
         end

         always_comb begin
            rem_sh  = {rem_prev, low_prev[QW-1]};
            rem_sub = rem_sh - {1'b0, den_prev};
            ge      = (rem_sh >= {1'b0, den_prev});
            rem_in  = ge ? rem_sub[SW-1:0] : rem_sh[SW-1:0];
         end

         always_ff @(posedge clock) begin
            rem_ff[k] <= rem_in;
            low_ff[k] <= {low_prev[QW-2:0], 1'b0};
            quo_ff[k] <= {quo_prev[QW-2:0], ge};
            den_ff[k] <= den_prev;
         end
      end
   endgenerate

   assign out_quo = quo_ff[QW-1];

endmodule

### bench/gradient_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// gradient_checker: color prediction and compare
// Watches config writes, point transfers and color transfers of the gradient
// converter, predicts each color in order and counts mismatches.
// ---------------------------------------------------------------------------
module gradient_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [gprgb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gprgb_pkg::SIZE_W-1:0]         csr_wr_data,
   input  logic                                 start,
   input  logic                                 busy,
   input  logic signed [gprgb_pkg::COORD_W-1:0] req_point_x,
   input  logic signed [gprgb_pkg::COORD_W-1:0] req_point_y,
   input  logic                                 rsp_valid,
   input  logic [7:0]                           rsp_red,
   input  logic [7:0]                           rsp_green,
   input  logic [7:0]                           rsp_blue,
   output int                                   error_count,
   output int                                   pending_colors,
   output int                                   colors_seen
);

   localparam int FB = gprgb_pkg::FRAC_BITS;
   localparam int SW = gprgb_pkg::SIZE_W;
   localparam longint unsigned ONE = 64'd1 << FB;

   logic [SW-1:0] width_q, height_q;
   logic [23:0] color_queue[$];

   function automatic longint unsigned to_byte(longint unsigned c);
      return ((c * 255) >> FB) & 8'hFF;
   endfunction

   function automatic logic [23:0] predict_color(
      logic signed [15:0] px, logic signed [15:0] py,
      logic [SW-1:0] wd, logic [SW-1:0] ht);
      longint signed xs, ys;
      longint unsigned x, y, half, h6, sector, f, s, v, p, q, t, r, g, b;
      xs = px;
      ys = py;
      if (xs > longint'(wd) - 1) xs = longint'(wd) - 1;
      if (xs < 0) xs = 0;
      if (ys > longint'(ht) - 1) ys = longint'(ht) - 1;
      if (ys < 0) ys = 0;
      x = xs;
      y = ys;
      half = ht / 2;
      h6 = (wd > 0) ? ((x * 6) << FB) / wd : 0;
      sector = h6 >> FB;
      f = h6 & (ONE - 1);
      if (y <= half) begin
         s = (half > 0) ? (y << FB) / half : 0;
         v = ONE;
      end else begin
         s = (half << FB) / y;
         v = ((2 * half - y) << FB) / y;
      end
      if (s > ONE) s = ONE;
      p = (v * (ONE - s)) >> FB;
      q = (v * (ONE - ((s * f) >> FB))) >> FB;
      t = (v * (ONE - ((s * (ONE - f)) >> FB))) >> FB;
      case (sector)
         0: begin r = v; g = t; b = p; end
         1: begin r = q; g = v; b = p; end
         2: begin r = p; g = v; b = t; end
         3: begin r = p; g = q; b = v; end
         4: begin r = t; g = p; b = v; end
         default: begin r = v; g = p; b = q; end
      endcase
      return {8'(to_byte(r)), 8'(to_byte(g)), 8'(to_byte(b))};
   endfunction

   assign pending_colors = color_queue.size();

   always @(posedge clock) begin
      logic [23:0] want;
      if (reset) begin
         width_q <= SW'(100);
         height_q <= SW'(150);
         error_count <= 0;
         colors_seen <= 0;
         color_queue.delete();
      end else begin
         if (rsp_valid) begin
            colors_seen <= colors_seen + 1;
            if (color_queue.size() == 0) begin
               if (error_count < 10)
                  $display("unexpected color transfer: got r%0d g%0d b%0d",
                           rsp_red, rsp_green, rsp_blue);
               error_count <= error_count + 1;
            end else begin
               want = color_queue.pop_front();
               if (want !== {rsp_red, rsp_green, rsp_blue}) begin
                  if (error_count < 10)
                     $display("color mismatch: exp r%0d g%0d b%0d got r%0d g%0d b%0d",
                              want[23:16], want[15:8], want[7:0],
                              rsp_red, rsp_green, rsp_blue);
                  error_count <= error_count + 1;
               end
            end
         end
         if (start && !busy)
            color_queue.push_back(predict_color(req_point_x, req_point_y,
                                                width_q, height_q));
         if (csr_wr_en) begin
            if (csr_index == gprgb_pkg::CSR_AREA_WIDTH) width_q <= csr_wr_data;
            else height_q <= csr_wr_data;
         end
      end
   end
endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: gradient point to RGB
// Drives directed and random points over several area sizes, with random
// gaps; the checker predicts and compares every color.
// ---------------------------------------------------------------------------
module testbench;

   localparam int LATENCY   = gprgb_pkg::QUO_W + 6;
   localparam int MAX_CYCLE = 400000;
   localparam int SW        = gprgb_pkg::SIZE_W;

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic [gprgb_pkg::CSR_IDX_W-1:0] csr_index = gprgb_pkg::CSR_AREA_WIDTH;
   logic [SW-1:0] csr_wr_data = 0;
   logic start = 0;
   logic busy;
   logic signed [gprgb_pkg::COORD_W-1:0] req_point_x = 0, req_point_y = 0;
   logic rsp_valid;
   logic [7:0] rsp_red, rsp_green, rsp_blue;
   int error_count, pending_colors, colors_seen;
   int cycle_count = 0;
   int points_sent = 0;

   always #1 clock = ~clock;

   gradient_point_to_rgb dut (.*);
   gradient_checker checker_inst (.*);

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLE) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic write_area(logic [SW-1:0] wd, logic [SW-1:0] ht);
      @(posedge clock);
      csr_wr_en <= 1; csr_index <= gprgb_pkg::CSR_AREA_WIDTH; csr_wr_data <= wd;
      @(posedge clock);
      csr_index <= gprgb_pkg::CSR_AREA_HEIGHT; csr_wr_data <= ht;
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   // drain every pending color, then the pipeline latency
   task automatic drain();
      while (pending_colors != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // one point transfer, with an optional random gap first
   task automatic send_point(logic signed [15:0] px, logic signed [15:0] py, bit gaps);
      int gap;
      gap = 0;
      if (gaps && $urandom_range(0, 3) == 0)
         gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1; req_point_x <= px; req_point_y <= py;
      @(posedge clock);
      while (busy) @(posedge clock);
      points_sent++;
   endtask

   function automatic logic signed [15:0] rand_coord(int size);
      case ($urandom_range(0, 9))
         0: return 16'($urandom());
         1: return 16'(-$urandom_range(1, 50));
         2: return 16'(size + $urandom_range(0, 50));
         default: return 16'($urandom_range(0, (size > 0) ? size - 1 : 0));
      endcase
   endfunction

   initial begin
      logic [SW-1:0] wd, ht;
      repeat (12) @(posedge clock);
      reset <= 0;

      // reset area 100x150: corners, halves, clamping, all sectors
      send_point(0, 0, 0);
      send_point(99, 149, 0);
      send_point(-32768, -32768, 0);
      send_point(32767, 32767, 0);
      send_point(16'sh5555, 16'shAAAA, 0);
      send_point(50, 75, 0);
      send_point(50, 76, 0);
      for (int k = 0; k < 6; k++) send_point(16'(k * 17 + 3), 40, 0);
      start <= 0;
      drain();
      // zero width, height below two
      write_area(0, 1);
      send_point(20, 0, 0);
      send_point(-5, 7, 0);
      start <= 0;
      drain();
      // odd height bottom row, largest area
      write_area(4095, 4095);
      send_point(4094, 4094, 0);
      send_point(2048, 2047, 0);
      send_point(4095, 4095, 0);
      start <= 0;
      drain();
      write_area(1, 2);
      send_point(0, 1, 0);
      send_point(3, -1, 0);
      start <= 0;
      drain();

      // random phases over several area sizes
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin wd = 4095; ht = 4095; end
            1: begin wd = 1; ht = 2; end
            2: begin wd = 0; ht = 0; end
            3: begin wd = 4095; ht = 3; end
            default: begin
               wd = SW'($urandom_range(1, 4095));
               ht = SW'($urandom_range(2, 4095));
            end
         endcase
         write_area(wd, ht);
         for (int n = 0; n < 125; n++) begin
            send_point(rand_coord(wd), rand_coord(ht), ph != 5);
            // hold off until everything has come back, once mid-phase
            if (ph == 4 && n == 60) begin
               start <= 0;
               while (pending_colors != 0) @(posedge clock);
            end
         end
         start <= 0;
         drain();
      end

      $display("sent %0d points over 12 area settings incl. zero and full size;", points_sent);
      $display("checked %0d colors with clamping, both halves and every sector", colors_seen);
      if (error_count == 0 && pending_colors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
